@@ rtl/ckms_pkg.sv @@
// ----------------------------------------------------------------------------
// ckms_pkg: shared types and constants of the capacitive key matrix scanner
// Field widths, register defaults and the structs passed between the
// sequencer, the key store and the top level.
// ----------------------------------------------------------------------------
package ckms_pkg;

  // Geometry limits and defaults
  localparam int RowsDef = 8;
  localparam int ColsDef = 16;
  localparam int RowW    = 3;
  localparam int ColW    = 4;
  localparam int BitsW   = 16;
  localparam int TickW   = 8;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SELECT_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECOVER      = 2'd2;

  // Register reset values
  localparam logic [TickW-1:0] SelectDelayRst = 8'd1;
  localparam logic [TickW-1:0] EnableRst      = 8'd2;
  localparam logic [TickW-1:0] RecoverRst     = 8'd25;

  // Store write request from the sequencer
  typedef struct packed {
    logic             we;
    logic [RowW-1:0]  row;
    logic [BitsW-1:0] data;
  } store_wr_t;

  // Per-item result fields produced by the sequencer
  typedef struct packed {
    logic [RowW-1:0] row_select;
    logic [ColW-1:0] col_select;
    logic            hys_drive;
    logic            enable_drive;
    logic            busy_res;
    logic            scan_done;
    logic            any_changed;
  } seq_res_t;

endpackage

@@ rtl/ckms_store.sv @@
// ----------------------------------------------------------------------------
// ckms_store: key matrix store
// One write port, two registered read ports with write-through. Rows not yet
// written read as zero through per-row valid bits cleared at reset.
// ----------------------------------------------------------------------------
module ckms_store #(
  parameter int ROWS = ckms_pkg::RowsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  ckms_pkg::store_wr_t        wr_i,
  input  logic [ckms_pkg::RowW-1:0]  addr_a_i,
  input  logic [ckms_pkg::RowW-1:0]  addr_b_i,
  output logic [ckms_pkg::BitsW-1:0] rdata_a_o,
  output logic [ckms_pkg::BitsW-1:0] rdata_b_o
);
  import ckms_pkg::*;

  localparam int RowAw = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [BitsW-1:0] mem_q [ROWS];
  logic [ROWS-1:0]  valid_q;
  logic [BitsW-1:0] rdata_a_q;
  logic [BitsW-1:0] rdata_b_q;
  logic [BitsW-1:0] rd_a_d;
  logic [BitsW-1:0] rd_b_d;
  logic             do_wr;

  assign do_wr = en_i && wr_i.we;

  // Read with write-through so the reported row reflects this item's update
  always_comb begin
    if (32'(addr_a_i) >= ROWS) begin
      rd_a_d = '0;
    end else if (do_wr && (wr_i.row == addr_a_i)) begin
      rd_a_d = wr_i.data;
    end else if (!valid_q[addr_a_i[RowAw-1:0]]) begin
      rd_a_d = '0;
    end else begin
      rd_a_d = mem_q[addr_a_i[RowAw-1:0]];
    end

    if (32'(addr_b_i) >= ROWS) begin
      rd_b_d = '0;
    end else if (do_wr && (wr_i.row == addr_b_i)) begin
      rd_b_d = wr_i.data;
    end else if (!valid_q[addr_b_i[RowAw-1:0]]) begin
      rd_b_d = '0;
    end else begin
      rd_b_d = mem_q[addr_b_i[RowAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_i.row[RowAw-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rdata_b_q <= '0;
    end else if (en_i) begin
      if (wr_i.we) begin
        valid_q[wr_i.row[RowAw-1:0]] <= 1'b1;
      end
      rdata_b_q <= rd_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_q <= rd_a_d;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/ckms_seq.sv @@
// ----------------------------------------------------------------------------
// ckms_seq: scan sequencer
// Phase, phase timer, key position and change flag; one time unit per
// accepted item. Also holds the timing registers.
// ----------------------------------------------------------------------------
module ckms_seq #(
  parameter int ROWS = ckms_pkg::RowsDef,
  parameter int COLS = ckms_pkg::ColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ckms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ckms_pkg::TickW-1:0]   cfg_wdata_i,
  input  logic                         acc_i,
  input  logic                         start_i,
  input  logic                         sense_i,
  input  logic [ckms_pkg::BitsW-1:0]   cur_bits_i,
  output ckms_pkg::seq_res_t           res_o,
  output ckms_pkg::store_wr_t          wr_o,
  output logic [ckms_pkg::RowW-1:0]    row_next_o
);
  import ckms_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SELECT  = 2'd1;
  localparam logic [1:0] PH_ENABLE  = 2'd2;
  localparam logic [1:0] PH_RECOVER = 2'd3;

  localparam logic [BitsW-1:0] ColMask = BitsW'((33'd1 << COLS) - 33'd1);
  localparam logic [RowW:0]    RowsN   = (RowW + 1)'(ROWS);
  localparam logic [ColW:0]    ColsN   = (ColW + 1)'(COLS);

  logic [TickW-1:0] sel_ticks_q, en_ticks_q, rec_ticks_q;
  logic [1:0]       phase_q, phase_d;
  logic [TickW-1:0] timer_q, timer_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             chg_q, chg_d;

  logic [1:0]       ph;
  logic             chg;
  logic             stored;
  logic             nb;
  logic             advance;
  logic             done;
  logic [TickW-1:0] tmr_inc;
  logic [BitsW-1:0] bit_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_ticks_q <= SelectDelayRst;
      en_ticks_q  <= EnableRst;
      rec_ticks_q <= RecoverRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SELECT_DELAY: sel_ticks_q <= cfg_wdata_i;
        CFG_ENABLE:       en_ticks_q  <= cfg_wdata_i;
        CFG_RECOVER:      rec_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // Start request from idle opens a scan at key 0
    ph  = phase_q;
    chg = chg_q;
    if ((phase_q == PH_IDLE) && start_i) begin
      ph  = PH_SELECT;
      chg = 1'b0;
    end

    stored  = cur_bits_i[col_q];
    nb      = ~sense_i;
    bit_sel = BitsW'(1) << col_q;
    tmr_inc = timer_q + 1'b1;
    advance = 1'b0;
    done    = 1'b0;

    phase_d = ph;
    timer_d = (ph == phase_q) ? timer_q : '0;
    row_d   = row_q;
    col_d   = col_q;
    chg_d   = chg;

    wr_o.we   = 1'b0;
    wr_o.row  = row_q;
    wr_o.data = nb ? ((cur_bits_i | bit_sel) & ColMask) : (cur_bits_i & ~bit_sel & ColMask);

    res_o.row_select   = row_q;
    res_o.col_select   = col_q;
    res_o.hys_drive    = 1'b0;
    res_o.enable_drive = 1'b0;
    res_o.busy_res     = (ph != PH_IDLE);

    case (ph)
      PH_SELECT: begin
        res_o.hys_drive = stored;
        if (timer_d < sel_ticks_q) begin
          timer_d = timer_d + 1'b1;
        end else begin
          phase_d = PH_ENABLE;
          timer_d = '0;
        end
      end
      PH_ENABLE: begin
        res_o.hys_drive    = stored;
        res_o.enable_drive = 1'b1;
        if (timer_q < en_ticks_q) begin
          timer_d = tmr_inc;
        end else begin
          // Sample the sense line into the stored bit
          wr_o.we = 1'b1;
          if (nb != stored) begin
            chg_d = 1'b1;
          end
          timer_d = '0;
          if (rec_ticks_q == '0) begin
            advance = 1'b1;
          end else begin
            phase_d = PH_RECOVER;
          end
        end
      end
      PH_RECOVER: begin
        timer_d = tmr_inc;
        if (tmr_inc >= rec_ticks_q) begin
          advance = 1'b1;
        end
      end
      default: ;
    endcase

    // Step to the next key, row inner and column outer
    if (advance) begin
      timer_d = '0;
      if (({1'b0, row_q} + 1'b1) < RowsN) begin
        row_d   = row_q + 1'b1;
        phase_d = PH_SELECT;
      end else begin
        row_d = '0;
        if (({1'b0, col_q} + 1'b1) < ColsN) begin
          col_d   = col_q + 1'b1;
          phase_d = PH_SELECT;
        end else begin
          col_d   = '0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
    end

    res_o.scan_done   = done;
    res_o.any_changed = done & chg_d;
  end

  assign row_next_o = row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      chg_q   <= 1'b0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      row_q   <= row_d;
      col_q   <= col_d;
      chg_q   <= chg_d;
    end
  end

  // A finished scan leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && res_o.scan_done |=> phase_q == PH_IDLE)
    else $error("ckms_seq: not idle after scan end");

  // The store is written only on the sample unit of the enable phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> phase_q == PH_ENABLE)
    else $error("ckms_seq: store write outside enable phase");

  // Idle always parks on key 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> row_q == '0 && col_q == '0)
    else $error("ckms_seq: idle away from key 0");

  // Key position stays inside the matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < RowsN) && ({1'b0, col_q} < ColsN))
    else $error("ckms_seq: key position out of range");

endmodule

@@ rtl/capacitive_key_matrix_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// capacitive_key_matrix_scanner_unit: capacitive key matrix scanner
// Sequences select, enable, sample and recovery for every key of the matrix
// and keeps the pressed state of each key with hysteresis feedback.
// ----------------------------------------------------------------------------
// Each input request is one time unit of the scan and yields exactly one
// result request. The unit takes a request in every clock cycle as long as
// the output register is empty or being drained; a result appears in the cycle
// after its request is taken and holds while m_axis_tready is low. A start
// request from idle begins a scan over all ROWS x COLS keys (rows inner,
// columns outer); each key costs select_delay_ticks + 1 select units,
// enable_ticks enable units, one sample unit and recover_ticks recovery
// units. The sense level is sampled on the sample unit, low meaning pressed.
// Hysteresis is driven while a key is selected and enabled if that key read
// pressed on the previous scan. The result that closes a scan carries tlast
// and the any_changed flag. row_bits always reports the stored row named by
// read_row, including any update made by the same request. The key store
// reads as all zero after reset with no clearing pass. Timing registers may
// be rewritten at any time and take effect on the next time unit.
// ----------------------------------------------------------------------------
module capacitive_key_matrix_scanner_unit #(
  parameter int ROWS = ckms_pkg::RowsDef,
  parameter int COLS = ckms_pkg::ColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Timing registers
  input  logic                         cfg_we_i,
  input  logic [ckms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ckms_pkg::TickW-1:0]   cfg_wdata_i,
  // Time-unit requests
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] scan_start, [1] key_sense, [4:2] read_row, [7:5] zero
  input  logic [7:0]                   s_axis_tdata,
  // Results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] row_select, [6:3] col_select, [7] hys_drive, [8] enable_drive,
  // [9] busy_res, [10] any_changed, [26:11] row_bits, [31:27] zero
  output logic [31:0]                  m_axis_tdata,
  // scan_done
  output logic                         m_axis_tlast
);
  import ckms_pkg::*;

  logic                acc;
  logic                out_valid_q;
  seq_res_t            res_q;
  seq_res_t            res;
  store_wr_t           wr;
  logic [RowW-1:0]     row_next;
  logic [BitsW-1:0]    cur_bits;
  logic [BitsW-1:0]    row_bits;

  // Accept whenever the output register is free or draining this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  ckms_seq #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .acc_i      (acc),
    .start_i    (s_axis_tdata[0]),
    .sense_i    (s_axis_tdata[1]),
    .cur_bits_i (cur_bits),
    .res_o      (res),
    .wr_o       (wr),
    .row_next_o (row_next)
  );

  // Port A feeds the reported row straight into the result; port B tracks
  // the row of the key under scan for the next time unit.
  ckms_store #(
    .ROWS(ROWS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (acc),
    .wr_i     (wr),
    .addr_a_i (s_axis_tdata[4:2]),
    .addr_b_i (row_next),
    .rdata_a_o(row_bits),
    .rdata_b_o(cur_bits)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.scan_done;
  assign m_axis_tdata  = {5'b0, row_bits, res_q.any_changed, res_q.busy_res,
                          res_q.enable_drive, res_q.hys_drive, res_q.col_select,
                          res_q.row_select};

endmodule
